// ===== design/wildcard_window_matcher_core_macros.svh =====
// ----------------------------------------------------------------------------
// wildcard window matcher assertion macros
// shared concurrent assertion forms for the matcher core
// ----------------------------------------------------------------------------
`ifndef WILDCARD_WINDOW_MATCHER_CORE_MACROS_SVH
`define WILDCARD_WINDOW_MATCHER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define WWM_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define WWM_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/wwm_pkg.sv =====
// ----------------------------------------------------------------------------
// wwm_pkg
// shared types and constants of the wildcard window matcher
// ----------------------------------------------------------------------------
package wwm_pkg;

    localparam int MAX_PATTERN_DEF   = 8;
    localparam int POSITION_BITS_DEF = 32;

    localparam int BYTE_W     = 8;
    localparam int PATTERN_W  = 64;
    localparam int LENGTH_W   = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int MATCH_W    = 32;

    localparam logic [BYTE_W-1:0] WILDCARD = 8'h2A;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES  = 1'b0,
        REG_PATTERN_LENGTH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern_bytes;
        logic [LENGTH_W-1:0]  pattern_length;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic drain;
    } stage_ctl_t;

endpackage

// ===== design/wwm_window.sv =====
// ----------------------------------------------------------------------------
// wwm_window
// input stage: byte window shift line, text position and fill count
// ----------------------------------------------------------------------------
module wwm_window #(
    parameter int MAX_PATTERN   = wwm_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = wwm_pkg::POSITION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wwm_pkg::stage_ctl_t                 ctl,
    input  logic [wwm_pkg::BYTE_W-1:0]          text_byte,
    input  logic                                text_start,
    output logic [wwm_pkg::BYTE_W-1:0]          window [MAX_PATTERN],
    output logic [POSITION_BITS-1:0]            bytes_seen,
    output logic [$clog2(MAX_PATTERN+1)-1:0]    window_fill,
    output logic                                stage_valid
);
    import wwm_pkg::*;

    localparam int FillW = $clog2(MAX_PATTERN + 1);

    logic [BYTE_W-1:0]        win_reg [MAX_PATTERN];
    logic [POSITION_BITS-1:0] seen_reg, seen_next;
    logic [FillW-1:0]         fill_reg, fill_next;
    logic                     valid_reg, valid_next;

    always_comb begin
        if (text_start) begin
            seen_next = POSITION_BITS'(1);
            fill_next = FillW'(1);
        end else begin
            seen_next = seen_reg + POSITION_BITS'(1);
            fill_next = (fill_reg < FillW'(MAX_PATTERN)) ? fill_reg + FillW'(1) : fill_reg;
        end
    end

    always_comb begin
        if (ctl.load) begin
            valid_next = 1'b1;
        end else if (ctl.drain) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= '0;
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (ctl.load) begin
                seen_reg <= seen_next;
                fill_reg <= fill_next;
            end
        end
    end

    // newest byte at entry 0
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            win_reg[0] <= text_byte;
            for (int k = 1; k < MAX_PATTERN; k++) begin
                win_reg[k] <= text_start ? '0 : win_reg[k-1];
            end
        end
    end

    assign window      = win_reg;
    assign bytes_seen  = seen_reg;
    assign window_fill = fill_reg;
    assign stage_valid = valid_reg;

endmodule

// ===== design/wwm_compare.sv =====
// ----------------------------------------------------------------------------
// wwm_compare
// parallel wildcard compare of the window against the pattern
// ----------------------------------------------------------------------------
module wwm_compare #(
    parameter int MAX_PATTERN   = wwm_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = wwm_pkg::POSITION_BITS_DEF
) (
    input  wwm_pkg::cfg_t                       cfg,
    input  logic [wwm_pkg::BYTE_W-1:0]          window [MAX_PATTERN],
    input  logic [POSITION_BITS-1:0]            bytes_seen,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]    window_fill,
    output logic                                hit,
    output logic [wwm_pkg::MATCH_W-1:0]         match_start
);
    import wwm_pkg::*;

    localparam int FillW = $clog2(MAX_PATTERN + 1);
    localparam int IdxW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int ExtW  = (POSITION_BITS > MATCH_W) ? POSITION_BITS : MATCH_W;

    logic [FillW-1:0]         len;
    logic [POSITION_BITS-1:0] start_pos;
    logic [ExtW-1:0]          start_ext;

    // zero acts as one, oversize clamps to the window depth
    always_comb begin
        if (cfg.pattern_length == '0) begin
            len = FillW'(1);
        end else if (cfg.pattern_length > LENGTH_W'(MAX_PATTERN)) begin
            len = FillW'(MAX_PATTERN);
        end else begin
            len = FillW'(cfg.pattern_length);
        end
    end

    always_comb begin
        logic [IdxW-1:0]   idx;
        logic [BYTE_W-1:0] pat;
        hit = (window_fill >= len);
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pat = cfg.pattern_bytes[BYTE_W*k +: BYTE_W];
            idx = IdxW'(len - FillW'(k) - FillW'(1));
            if (FillW'(k) < len) begin
                if (pat != WILDCARD && pat != window[idx]) begin
                    hit = 1'b0;
                end
            end
        end
    end

    assign start_pos   = bytes_seen - POSITION_BITS'(len);
    assign start_ext   = ExtW'(start_pos);
    assign match_start = start_ext[MATCH_W-1:0];

endmodule

// ===== design/wildcard_window_matcher_core.sv =====
// ----------------------------------------------------------------------------
// wildcard_window_matcher_core
// Streams text one byte per transaction and reports the start position of
// every window of the last pattern_length bytes that matches the configured
// pattern, where a '*' pattern byte matches any byte. A set text_start clears
// the window and the position count before its byte is taken. The core takes
// one byte per cycle while results drain; each byte passes through two
// register stages (window register, then result register). The byte enters
// the window register when it is accepted, and its result is loaded into
// the result register once the window stage drains, which waits while an
// untaken result is held. The parallel compare of all window bytes sits
// between those two stages. The core does not check that configuration is
// written only while no transaction is in flight; the user must ensure it.
// ----------------------------------------------------------------------------
module wildcard_window_matcher_core #(
    parameter int MAX_PATTERN   = wwm_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = wwm_pkg::POSITION_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [wwm_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [wwm_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [wwm_pkg::BYTE_W-1:0]         s_text_byte,
    input  logic                               s_text_start,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [wwm_pkg::MATCH_W-1:0]        m_match_start
);
    import wwm_pkg::*;
    `include "wildcard_window_matcher_core_macros.svh"

    localparam int FillW = $clog2(MAX_PATTERN + 1);

    cfg_t                     cfg_reg;
    stage_ctl_t               ctl;
    logic [BYTE_W-1:0]        window [MAX_PATTERN];
    logic [POSITION_BITS-1:0] bytes_seen;
    logic [FillW-1:0]         window_fill;
    logic                     stage_valid;
    logic                     hit;
    logic [MATCH_W-1:0]       match_start;
    logic                     m_valid_reg, m_valid_next;
    logic [MATCH_W-1:0]       m_match_start_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_bytes  <= '0;
            cfg_reg.pattern_length <= LENGTH_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_index))
                REG_PATTERN_BYTES:  cfg_reg.pattern_bytes  <= cfg_wr_data[PATTERN_W-1:0];
                REG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg_wr_data[LENGTH_W-1:0];
            endcase
        end
    end

    assign ctl.drain = stage_valid && (!m_valid_reg || m_ready);
    assign s_ready   = !stage_valid || ctl.drain;
    assign ctl.load  = s_valid && s_ready;

    wwm_window #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .text_byte   (s_text_byte),
        .text_start  (s_text_start),
        .window      (window),
        .bytes_seen  (bytes_seen),
        .window_fill (window_fill),
        .stage_valid (stage_valid)
    );

    wwm_compare #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_compare (
        .cfg         (cfg_reg),
        .window      (window),
        .bytes_seen  (bytes_seen),
        .window_fill (window_fill),
        .hit         (hit),
        .match_start (match_start)
    );

    // result register
    always_comb begin
        if (ctl.drain) begin
            m_valid_next = hit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.drain && hit) begin
            m_match_start_reg <= match_start;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match_start = m_match_start_reg;

    `WWM_ASSERT_IMPL(a_block_when_full, aclk, aresetn,
        stage_valid && m_valid_reg && !m_ready, !s_ready, "input taken while both stages full")
    `WWM_ASSERT_NEXT(a_load_sets_stage, aclk, aresetn,
        ctl.load, stage_valid, "accepted byte lost before compare")
    `WWM_ASSERT_NEXT(a_start_clears, aclk, aresetn,
        ctl.load && s_text_start,
        (bytes_seen == POSITION_BITS'(1)) && (window_fill == FillW'(1)),
        "text start did not restart position and fill")
    `WWM_ASSERT_IMPL(a_fill_range, aclk, aresetn,
        stage_valid, (window_fill != '0) && (window_fill <= FillW'(MAX_PATTERN)),
        "window fill out of range")
    `WWM_ASSERT_NEXT(a_miss_no_result, aclk, aresetn,
        ctl.drain && !hit, !m_valid, "result raised without a match")

endmodule

// ===== tb/wildcard_window_matcher_core_checker.sv =====
// ----------------------------------------------------------------------------
// wildcard window matcher checker
// Watches the configuration port and both streams of the matcher core. It
// keeps its own copy of the pattern registers, the byte window and the text
// position, works out the start position that each matching text byte
// should report, and compares every result transaction against the oldest
// pending start position.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wildcard_window_matcher_core_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [wwm_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [wwm_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [wwm_pkg::BYTE_W-1:0]     s_text_byte,
    input  logic                           s_text_start,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [wwm_pkg::MATCH_W-1:0]    m_match_start,
    output int                             mismatch_count,
    output int                             pending_matches
);
    import wwm_pkg::*;

    localparam int WINDOW_DEPTH = MAX_PATTERN_DEF;

    logic [PATTERN_W-1:0]         pattern_bytes;
    logic [LENGTH_W-1:0]          pattern_length;
    logic [BYTE_W-1:0]            window_bytes [WINDOW_DEPTH];
    logic [POSITION_BITS_DEF-1:0] text_position;
    int                           window_fill;
    logic [MATCH_W-1:0]           expected_starts [$];

    function automatic logic slide_and_match(input logic [BYTE_W-1:0] text_byte,
                                             input logic text_start,
                                             output logic [MATCH_W-1:0] start_pos);
        int len;
        logic hit;
        logic [BYTE_W-1:0] pat;
        if (text_start) begin
            foreach (window_bytes[k]) window_bytes[k] = '0;
            text_position = '0;
            window_fill = 0;
        end
        for (int k = WINDOW_DEPTH - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
        window_bytes[0] = text_byte;
        text_position = text_position + 1'b1;
        if (window_fill < WINDOW_DEPTH) window_fill++;
        len = int'(pattern_length);
        if (len < 1) len = 1;
        if (len > WINDOW_DEPTH) len = WINDOW_DEPTH;
        hit = (window_fill >= len);
        for (int k = 0; k < len; k++) begin
            pat = pattern_bytes[8*k +: 8];
            if (pat != WILDCARD && pat != window_bytes[len-1-k]) hit = 1'b0;
        end
        start_pos = MATCH_W'(text_position - POSITION_BITS_DEF'(len));
        return hit;
    endfunction

    always @(posedge aclk) begin
        logic [MATCH_W-1:0] start_pos;
        logic [MATCH_W-1:0] oldest;
        if (!aresetn) begin
            pattern_bytes = '0;
            pattern_length = LENGTH_W'(1);
            foreach (window_bytes[k]) window_bytes[k] = '0;
            text_position = '0;
            window_fill = 0;
            expected_starts.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_starts.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, got %0d",
                             $time, m_match_start);
                    mismatch_count++;
                end else begin
                    oldest = expected_starts.pop_front();
                    if (m_match_start !== oldest) begin
                        $display("%0t: match_start mismatch, expected %0d, got %0d",
                                 $time, oldest, m_match_start);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_wr_index))
                    REG_PATTERN_BYTES: begin
                        pattern_bytes = cfg_wr_data[PATTERN_W-1:0];
                    end
                    REG_PATTERN_LENGTH: begin
                        pattern_length = cfg_wr_data[LENGTH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                if (slide_and_match(s_text_byte, s_text_start, start_pos))
                    expected_starts.push_back(start_pos);
            end
        end
        pending_matches = expected_starts.size();
    end

endmodule

// ===== tb/wildcard_window_matcher_core_test.sv =====
// ----------------------------------------------------------------------------
// wildcard window matcher testbench
// Drives text streams and pattern settings into the matcher core: a directed
// pass over the reset pattern, short texts, wildcards, out-of-range lengths
// and a length change inside a text, then random phases of texts that often
// carry pattern instances. Both streams idle in random bursts, except at the
// end. The checker predicts and compares every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wildcard_window_matcher_core_test;
    import wwm_pkg::*;

    localparam int TOTAL_ITEMS    = 1200;
    localparam int CALM_ITEMS     = 200;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [BYTE_W-1:0] CHAR_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_B = 8'h62;
    localparam logic [BYTE_W-1:0] CHAR_C = 8'h63;
    localparam logic [BYTE_W-1:0] CHAR_D = 8'h64;
    localparam logic [BYTE_W-1:0] CHAR_Z = 8'h5A;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_text_byte = '0;
    logic                  s_text_start = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [MATCH_W-1:0]    m_match_start;

    int                    mismatch_count;
    int                    pending_matches;
    logic                  gaps_enabled = 1'b1;
    int                    items_sent = 0;
    int                    stall_left = 0;
    int                    quiet_cycles = 0;
    logic [PATTERN_W-1:0]  cur_pattern = '0;
    int                    cur_len = 1;

    wildcard_window_matcher_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_text_start  (s_text_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_start (m_match_start)
    );

    wildcard_window_matcher_core_checker match_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_byte     (s_text_byte),
        .s_text_start    (s_text_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_match_start   (m_match_start),
        .mismatch_count  (mismatch_count),
        .pending_matches (pending_matches)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (gaps_enabled && $urandom_range(0, 9) == 0) begin
            m_ready = 1'b0;
            stall_left = $urandom_range(1, 18) - 1;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic [BYTE_W-1:0] alphabet_char();
        case ($urandom_range(0, 2))
            0: return CHAR_A;
            1: return CHAR_B;
            default: return CHAR_C;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] random_text_char();
        if ($urandom_range(0, 7) == 0) return BYTE_W'($urandom_range(0, 255));
        return alphabet_char();
    endfunction

    function automatic logic [PATTERN_W-1:0] alphabet_pattern();
        logic [PATTERN_W-1:0] pattern;
        for (int k = 0; k < MAX_PATTERN_DEF; k++)
            pattern[8*k +: 8] = ($urandom_range(0, 3) == 0) ? WILDCARD : alphabet_char();
        return pattern;
    endfunction

    task automatic send_text_byte(input logic [BYTE_W-1:0] text_byte, input logic text_start);
        logic taken;
        if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_text_byte = text_byte;
        s_text_start = text_start;
        do begin
            @(posedge aclk);
            taken = s_ready;
            @(negedge aclk);
        end while (!taken);
        items_sent++;
    endtask

    task automatic settle_pipeline();
        s_valid = 1'b0;
        while (pending_matches != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_wr_index = index;
        cfg_wr_data = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic load_pattern(input logic [PATTERN_W-1:0] pattern,
                                input logic [CFG_DATA_W-1:0] length_word);
        int raw;
        settle_pipeline();
        write_reg(REG_PATTERN_BYTES, pattern);
        write_reg(REG_PATTERN_LENGTH, length_word);
        raw = int'(length_word[LENGTH_W-1:0]);
        cur_pattern = pattern;
        cur_len = (raw == 0) ? 1 : (raw > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : raw;
    endtask

    task automatic send_text(input int text_len, input logic fresh);
        int pos;
        logic [BYTE_W-1:0] text_byte;
        pos = 0;
        while (pos < text_len) begin
            if ($urandom_range(0, 4) == 0 && pos + cur_len <= text_len) begin
                for (int k = 0; k < cur_len; k++) begin
                    text_byte = cur_pattern[8*k +: 8];
                    if (text_byte == WILDCARD) text_byte = BYTE_W'($urandom_range(0, 255));
                    send_text_byte(text_byte, fresh && pos == 0);
                    pos++;
                end
            end else begin
                send_text_byte(random_text_char(), fresh && pos == 0);
                pos++;
            end
        end
    endtask

    initial begin
        int phase;
        int raw_len;
        int target;
        logic continue_text;
        logic [CFG_DATA_W-1:0] length_word;
        logic [PATTERN_W-1:0] pattern;

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // reset pattern, stream continues without a start flag
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h00, 1'b0);

        // short text, then wildcard hits including a literal star
        load_pattern(64'h0000_0000_642A_6261, 64'd4);
        send_text_byte(CHAR_A, 1'b1);
        send_text_byte(CHAR_B, 1'b0);
        send_text_byte(CHAR_A, 1'b1);
        send_text_byte(CHAR_B, 1'b0);
        send_text_byte(CHAR_Z, 1'b0);
        send_text_byte(CHAR_D, 1'b0);
        send_text_byte(CHAR_A, 1'b0);
        send_text_byte(CHAR_B, 1'b0);
        send_text_byte(WILDCARD, 1'b0);
        send_text_byte(CHAR_D, 1'b0);

        // zero length behaves as one
        load_pattern({PATTERN_W{1'b1}}, 64'd0);
        send_text_byte(8'hFF, 1'b1);
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);

        // oversized length clamps to the full window
        load_pattern({MAX_PATTERN_DEF{WILDCARD}}, 64'd15);
        for (int k = 0; k < 9; k++)
            send_text_byte(BYTE_W'($urandom_range(0, 255)), k == 0);

        // shorter length inside the running text
        load_pattern(cur_pattern, 64'd2);
        send_text_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            gaps_enabled = (items_sent < TOTAL_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            case (phase % 6)
                0: raw_len = 1;
                1: raw_len = MAX_PATTERN_DEF;
                2: raw_len = 0;
                3: raw_len = $urandom_range(MAX_PATTERN_DEF + 1, 15);
                default: raw_len = $urandom_range(2, MAX_PATTERN_DEF - 1);
            endcase
            length_word = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
            length_word[LENGTH_W-1:0] = LENGTH_W'(raw_len);
            pattern = (phase % 5 == 4) ? {$urandom, $urandom} : alphabet_pattern();
            load_pattern(pattern, length_word);
            continue_text = ($urandom_range(0, 3) == 0);
            target = items_sent + $urandom_range(60, 120);
            while (items_sent < target) begin
                send_text(($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                      : $urandom_range(4, 24),
                          !continue_text);
                continue_text = 1'b0;
                if ($urandom_range(0, 29) == 0) settle_pipeline();
            end
            phase++;
        end

        settle_pipeline();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
